// File: rtl/core/tmb_pkg.sv
`default_nettype none

package tmb_pkg;

    // tick field widths
    localparam int PRICE_W = 31;
    localparam int DATE_W  = 27;
    localparam int TIME_W  = 28;
    localparam int VOL_W   = 48;
    localparam int TURN_W  = 56;

    // bar quantity width, two's complement
    localparam int BAR_W = 64;

    // time of day modulo one minute code, and the factor magnitude of a share term
    localparam int MOD_W  = 17;
    localparam int FMAG_W = 17;

    // exact product of a quantity difference and a time factor
    localparam int PROD_W = TURN_W + FMAG_W;

    // step counter of the serial multiply and divide
    localparam int CNT_W = $clog2(PROD_W);

    localparam logic [MOD_W-1:0]  MINUTE_MS  = MOD_W'(60000);
    localparam logic [TIME_W-1:0] MINUTE_MOD = TIME_W'(100000);

    // slave-side word layout, lowest bit first
    localparam int S_PRICE_LSB  = 0;
    localparam int S_DATE_LSB   = S_PRICE_LSB + PRICE_W;
    localparam int S_TIME_LSB   = S_DATE_LSB + DATE_W;
    localparam int S_VOL_LSB    = S_TIME_LSB + TIME_W;
    localparam int S_TURN_LSB   = S_VOL_LSB + VOL_W;
    localparam int S_FIELDS_W   = S_TURN_LSB + TURN_W;
    localparam int S_DATA_W     = ((S_FIELDS_W + 7) / 8) * 8;

    // master-side word layout, lowest bit first
    localparam int M_FIELDS_W = DATE_W + TIME_W + 5 * PRICE_W + 2 * BAR_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

endpackage

`default_nettype wire

// File: rtl/core/tick_to_minute_bar.sv
`default_nettype none

// One-minute bar builder. Ticks arrive on the slave side, one per word; s_tuser is
// high on the first tick of a new minute, and that tick closes the minute before it
// and comes out as one bar word on the master side (no bar before a minute has been
// opened, and the first marked tick after some traffic only opens one). Volume and
// turnover are shared out by time at the minute edges, each share term being
// (dQ * time factor) / dt, formed exactly and truncated toward zero; a zero dt gives
// a zero term. Time reduction, multiply and divide run one bit per cycle through a
// single restoring divider and a shift-add multiplier. Every tick first reduces its
// time modulo 100000 on the divider and is then stored; only after that is the next
// tick taken. Between the two, a closing tick runs four share terms, each a setup,
// 17 multiply steps, 73 divide steps and an accumulate; an opening-edge term whose
// pre-minute quantity is zero is skipped at its setup instead. The bar sits in an
// output register; the next tick is taken while it waits, and only a second bar
// stalls until the first has been read.
module tick_to_minute_bar
    import tmb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,

    input  logic                s_tvalid,
    output logic                s_tready,
    // price, tick_date, tick_time, cum_volume, cum_turnover, zero fill
    input  logic [S_DATA_W-1:0] s_tdata,
    // new_minute
    input  logic                s_tuser,

    output logic                m_tvalid,
    input  logic                m_tready,
    // bar_date, bar_time, pre_close, open_price, close_price, high_price, low_price,
    // bar_volume, bar_turnover, zero fill
    output logic [M_DATA_W-1:0] m_tdata
);

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MOD    = 3'd1;
    localparam logic [2:0] ST_SETUP  = 3'd2;
    localparam logic [2:0] ST_MUL    = 3'd3;
    localparam logic [2:0] ST_DIV    = 3'd4;
    localparam logic [2:0] ST_ACCUM  = 3'd5;
    localparam logic [2:0] ST_UPDATE = 3'd6;

    // share terms in the order they run; bit 0 marks the closing edge, bit 1 turnover
    localparam logic [1:0] TERM_VOL_FIRST  = 2'd0;
    localparam logic [1:0] TERM_VOL_EDGE   = 2'd1;
    localparam logic [1:0] TERM_TURN_FIRST = 2'd2;
    localparam logic [1:0] TERM_TURN_EDGE  = 2'd3;

    logic [2:0]           state_reg, state_next;
    logic                 bar_open_reg;
    logic                 seen_reg;
    logic                 m_tvalid_reg;
    logic [M_DATA_W-1:0]  m_tdata_reg;

    // tick being worked on
    logic [PRICE_W-1:0]   cur_price_reg;
    logic [DATE_W-1:0]    cur_date_reg;
    logic [TIME_W-1:0]    cur_time_reg;
    logic [VOL_W-1:0]     cur_vol_reg;
    logic [TURN_W-1:0]    cur_turn_reg;
    logic                 cur_mark_reg;
    logic [MOD_W-1:0]     cur_mod_reg;

    // tick before the minute
    logic [PRICE_W-1:0]   st_price_reg;
    logic [TIME_W-1:0]    st_time_reg;
    logic [VOL_W-1:0]     st_vol_reg;
    logic [TURN_W-1:0]    st_turn_reg;

    // first tick of the minute
    logic [PRICE_W-1:0]   fs_price_reg;
    logic [TIME_W-1:0]    fs_time_reg;
    logic [VOL_W-1:0]     fs_vol_reg;
    logic [TURN_W-1:0]    fs_turn_reg;
    logic [MOD_W-1:0]     fs_mod_reg;

    // latest tick
    logic [PRICE_W-1:0]   ls_price_reg;
    logic [TIME_W-1:0]    ls_time_reg;
    logic [VOL_W-1:0]     ls_vol_reg;
    logic [TURN_W-1:0]    ls_turn_reg;
    logic [MOD_W-1:0]     ls_mod_reg;

    logic [PRICE_W-1:0]   high_reg;
    logic [PRICE_W-1:0]   low_reg;

    // serial arithmetic
    logic [CNT_W-1:0]     cnt_reg;
    logic [1:0]           term_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [FMAG_W-1:0]    fsh_reg;
    logic [TURN_W-1:0]    mag_reg;
    logic [TIME_W-1:0]    dvs_reg;
    logic [TIME_W-1:0]    rem_reg;
    logic [BAR_W-1:0]     quo_reg;
    logic                 neg_reg;
    logic                 dzero_reg;
    logic [BAR_W-1:0]     acc_vol_reg;
    logic [BAR_W-1:0]     acc_turn_reg;

    // share term operands
    logic                 op_edge;
    logic                 op_turn;
    logic [TURN_W-1:0]    op_hi;
    logic [TURN_W-1:0]    op_lo;
    logic [TIME_W-1:0]    op_thi;
    logic [TIME_W-1:0]    op_tlo;
    logic [FMAG_W-1:0]    op_fmag;
    logic                 op_fneg;
    logic                 op_skip;
    logic [TURN_W-1:0]    op_mag;
    logic [TIME_W-1:0]    op_dmag;

    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      trial_diff;
    logic                 div_ge;
    logic [TIME_W-1:0]    rem_step;
    logic [PROD_W-1:0]    prod_mul;
    logic [BAR_W-1:0]     addend;
    logic [BAR_W-1:0]     acc_sum;
    logic [BAR_W-1:0]     vol_base;
    logic [BAR_W-1:0]     turn_base;

    logic                 cnt_done;
    logic                 emit;
    logic                 upd_go;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign cnt_done = (cnt_reg == '0);
    assign emit     = cur_mark_reg && bar_open_reg;
    // a second bar waits until the first one has been read
    assign upd_go   = (state_reg == ST_UPDATE) && !(emit && m_tvalid_reg && !m_tready);

    // operand selection for the current share term
    always_comb
    begin
        op_edge = term_reg[0];
        op_turn = term_reg[1];
        if (op_edge)
        begin
            // closing edge: marking tick against latest tick, factor 60000 - time mod
            op_hi  = op_turn ? cur_turn_reg : TURN_W'(cur_vol_reg);
            op_lo  = op_turn ? ls_turn_reg : TURN_W'(ls_vol_reg);
            op_thi = cur_time_reg;
            op_tlo = ls_time_reg;
            if (ls_mod_reg <= MINUTE_MS)
            begin
                op_fmag = MINUTE_MS - ls_mod_reg;
                op_fneg = 1'b0;
            end
            else
            begin
                op_fmag = ls_mod_reg - MINUTE_MS;
                op_fneg = 1'b1;
            end
            op_skip = 1'b0;
        end
        else
        begin
            // opening edge: first tick against the tick before the minute
            op_hi   = op_turn ? fs_turn_reg : TURN_W'(fs_vol_reg);
            op_lo   = op_turn ? st_turn_reg : TURN_W'(st_vol_reg);
            op_thi  = fs_time_reg;
            op_tlo  = st_time_reg;
            op_fmag = fs_mod_reg;
            op_fneg = 1'b0;
            // zero pre-minute quantity: only the closing edge is shared out
            op_skip = (op_lo == '0);
        end
        op_mag  = (op_hi >= op_lo) ? (op_hi - op_lo) : (op_lo - op_hi);
        op_dmag = (op_thi >= op_tlo) ? (op_thi - op_tlo) : (op_tlo - op_thi);
    end

    // one restoring divide step, one shift-add multiply step, one accumulate
    always_comb
    begin
        trial      = {rem_reg, prod_reg[PROD_W-1]};
        trial_diff = trial - {1'b0, dvs_reg};
        div_ge     = (trial >= {1'b0, dvs_reg});
        rem_step   = div_ge ? trial_diff[TIME_W-1:0] : trial[TIME_W-1:0];

        prod_mul = {prod_reg[PROD_W-2:0], 1'b0}
                 + (fsh_reg[FMAG_W-1] ? PROD_W'(mag_reg) : PROD_W'(0));

        // conditional negate folded into the adder carry
        addend  = dzero_reg ? '0 : (quo_reg ^ {BAR_W{neg_reg}});
        acc_sum = (op_turn ? acc_turn_reg : acc_vol_reg) + addend
                + BAR_W'(neg_reg && !dzero_reg);

        // latest-tick quantity, less first-tick quantity when the minute has a start
        vol_base  = BAR_W'(ls_vol_reg)
                  - ((st_vol_reg == '0) ? BAR_W'(0) : BAR_W'(fs_vol_reg));
        turn_base = BAR_W'(ls_turn_reg)
                  - ((st_turn_reg == '0) ? BAR_W'(0) : BAR_W'(fs_turn_reg));
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                    state_next = ST_MOD;
            end
            ST_MOD:
            begin
                if (cnt_done)
                    state_next = emit ? ST_SETUP : ST_UPDATE;
            end
            ST_SETUP:
            begin
                if (!op_skip)
                    state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (cnt_done)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (cnt_done)
                    state_next = ST_ACCUM;
            end
            ST_ACCUM:
            begin
                state_next = (term_reg == TERM_TURN_EDGE) ? ST_UPDATE : ST_SETUP;
            end
            ST_UPDATE:
            begin
                if (upd_go)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            bar_open_reg <= 1'b0;
            seen_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (upd_go)
            begin
                seen_reg <= 1'b1;
                if (cur_mark_reg && seen_reg)
                    bar_open_reg <= 1'b1;
            end
            if (upd_go && emit)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cur_price_reg <= s_tdata[S_PRICE_LSB +: PRICE_W];
                    cur_date_reg  <= s_tdata[S_DATE_LSB +: DATE_W];
                    cur_time_reg  <= s_tdata[S_TIME_LSB +: TIME_W];
                    cur_vol_reg   <= s_tdata[S_VOL_LSB +: VOL_W];
                    cur_turn_reg  <= s_tdata[S_TURN_LSB +: TURN_W];
                    cur_mark_reg  <= s_tuser;
                    // time reduced modulo 100000 on the divider, msb first
                    prod_reg      <= {s_tdata[S_TIME_LSB +: TIME_W], (PROD_W-TIME_W)'(0)};
                    rem_reg       <= '0;
                    dvs_reg       <= MINUTE_MOD;
                    cnt_reg       <= CNT_W'(TIME_W - 1);
                end
            end
            ST_MOD:
            begin
                prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                rem_reg  <= rem_step;
                cnt_reg  <= cnt_reg - 1'b1;
                if (cnt_done)
                begin
                    cur_mod_reg  <= rem_step[MOD_W-1:0];
                    acc_vol_reg  <= vol_base;
                    acc_turn_reg <= turn_base;
                    term_reg     <= TERM_VOL_FIRST;
                end
            end
            ST_SETUP:
            begin
                if (op_skip)
                begin
                    term_reg <= term_reg + 1'b1;
                end
                else
                begin
                    mag_reg   <= op_mag;
                    fsh_reg   <= op_fmag;
                    dvs_reg   <= op_dmag;
                    neg_reg   <= (op_hi < op_lo) ^ op_fneg ^ (op_thi < op_tlo);
                    dzero_reg <= (op_thi == op_tlo);
                    prod_reg  <= '0;
                    cnt_reg   <= CNT_W'(FMAG_W - 1);
                end
            end
            ST_MUL:
            begin
                prod_reg <= prod_mul;
                fsh_reg  <= {fsh_reg[FMAG_W-2:0], 1'b0};
                if (cnt_done)
                begin
                    rem_reg <= '0;
                    cnt_reg <= CNT_W'(PROD_W - 1);
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
            ST_DIV:
            begin
                // quotient bits above the bar width drop off the top
                prod_reg <= {prod_reg[PROD_W-2:0], 1'b0};
                rem_reg  <= rem_step;
                quo_reg  <= {quo_reg[BAR_W-2:0], div_ge};
                cnt_reg  <= cnt_reg - 1'b1;
            end
            ST_ACCUM:
            begin
                if (op_turn)
                    acc_turn_reg <= acc_sum;
                else
                    acc_vol_reg <= acc_sum;
                term_reg <= term_reg + 1'b1;
            end
            ST_UPDATE:
            begin
                if (upd_go)
                begin
                    if (emit)
                        m_tdata_reg <= {{(M_DATA_W-M_FIELDS_W){1'b0}},
                                        acc_turn_reg, acc_vol_reg,
                                        low_reg, high_reg,
                                        ls_price_reg, fs_price_reg, st_price_reg,
                                        ls_time_reg, cur_date_reg};
                    if (cur_mark_reg)
                    begin
                        if (seen_reg)
                        begin
                            st_price_reg <= ls_price_reg;
                            st_time_reg  <= ls_time_reg;
                            st_vol_reg   <= ls_vol_reg;
                            st_turn_reg  <= ls_turn_reg;
                            fs_price_reg <= cur_price_reg;
                            fs_time_reg  <= cur_time_reg;
                            fs_vol_reg   <= cur_vol_reg;
                            fs_turn_reg  <= cur_turn_reg;
                            fs_mod_reg   <= cur_mod_reg;
                            high_reg     <= cur_price_reg;
                            low_reg      <= cur_price_reg;
                        end
                    end
                    else if (bar_open_reg)
                    begin
                        if (cur_price_reg > high_reg)
                            high_reg <= cur_price_reg;
                        if (cur_price_reg < low_reg)
                            low_reg <= cur_price_reg;
                    end
                    ls_price_reg <= cur_price_reg;
                    ls_time_reg  <= cur_time_reg;
                    ls_vol_reg   <= cur_vol_reg;
                    ls_turn_reg  <= cur_turn_reg;
                    ls_mod_reg   <= cur_mod_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/core/tmb_checker.sv
`default_nettype none

module tmb_checker
    import tmb_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    // a stalled bar word holds
    a_bar_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("bar word changed while stalled");

    // one tick at a time
    a_one_tick: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("tick taken while busy");

    // time reduction keeps the core busy
    a_mod_len: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> ##29 !s_tready)
        else $error("tick finished too early");

    // a bar appears only as the core returns to idle
    a_bar_idle: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> s_tready)
        else $error("bar raised while core busy");

    a_rst_quiet: assert property (@(posedge clk)
        !rst_n |-> !m_tvalid)
        else $error("bar valid during reset");

endmodule

bind tick_to_minute_bar tmb_checker u_tmb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// File: verif/minute_bar_checker.sv
`timescale 1ns / 100ps

module minute_bar_checker
    import tmb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,
    input  logic                s_tuser,
    input  logic                m_tvalid,
    input  logic                m_tready,
    input  logic [M_DATA_W-1:0] m_tdata,
    output int                  mismatches,
    output int                  bars_pending
);

    typedef struct packed {
        logic [PRICE_W-1:0] price;
        logic [TIME_W-1:0]  stamp;
        logic [VOL_W-1:0]   vol;
        logic [TURN_W-1:0]  turn;
    } tick_t;

    // lowest field in the lowest bits
    typedef struct packed {
        logic [BAR_W-1:0]   turnover;
        logic [BAR_W-1:0]   volume;
        logic [PRICE_W-1:0] low_price;
        logic [PRICE_W-1:0] high_price;
        logic [PRICE_W-1:0] close_price;
        logic [PRICE_W-1:0] open_price;
        logic [PRICE_W-1:0] pre_close;
        logic [TIME_W-1:0]  bar_time;
        logic [DATE_W-1:0]  bar_date;
    } bar_t;

    logic               minute_open;
    logic               have_last;
    tick_t              start_tick;
    tick_t              first_tick;
    tick_t              last_tick;
    logic [PRICE_W-1:0] run_high;
    logic [PRICE_W-1:0] run_low;
    bar_t               expected_bars[$];

    // dq * factor / dt, exact and truncated toward zero, kept to 64 bits
    function automatic logic [BAR_W-1:0] time_share(input logic [TURN_W-1:0] q_hi,
                                                    input logic [TURN_W-1:0] q_lo,
                                                    input logic signed [19:0] factor,
                                                    input logic [TIME_W-1:0] t_hi,
                                                    input logic [TIME_W-1:0] t_lo);
        logic signed [127:0] num;
        logic signed [127:0] den;
        logic signed [127:0] quo;
        if (t_hi == t_lo)
            return '0;
        num = ($signed({72'd0, q_hi}) - $signed({72'd0, q_lo})) * factor;
        den = $signed({100'd0, t_hi}) - $signed({100'd0, t_lo});
        quo = num / den;
        return quo[BAR_W-1:0];
    endfunction

    function automatic logic [BAR_W-1:0] apportion(input logic [TURN_W-1:0] s_q,
                                                   input logic [TURN_W-1:0] f_q,
                                                   input logic [TURN_W-1:0] l_q,
                                                   input logic [TURN_W-1:0] e_q,
                                                   input logic [TIME_W-1:0] e_t);
        logic [BAR_W-1:0] close_share;
        close_share = time_share(e_q, l_q,
                                 20'(int'(MINUTE_MS) - int'(last_tick.stamp % MINUTE_MOD)),
                                 e_t, last_tick.stamp);
        if (s_q == '0)
            return BAR_W'(l_q) + close_share;
        return time_share(f_q, s_q, 20'(int'(first_tick.stamp % MINUTE_MOD)),
                          first_tick.stamp, start_tick.stamp)
               + (BAR_W'(l_q) - BAR_W'(f_q)) + close_share;
    endfunction

    task automatic take_tick(input tick_t cur, input logic [DATE_W-1:0] date,
                             input logic marker);
        bar_t bar;
        if (marker)
        begin
            if (minute_open)
            begin
                bar.bar_date    = date;
                bar.bar_time    = last_tick.stamp;
                bar.pre_close   = start_tick.price;
                bar.open_price  = first_tick.price;
                bar.close_price = last_tick.price;
                bar.high_price  = run_high;
                bar.low_price   = run_low;
                bar.volume      = apportion(TURN_W'(start_tick.vol), TURN_W'(first_tick.vol),
                                            TURN_W'(last_tick.vol), TURN_W'(cur.vol),
                                            cur.stamp);
                bar.turnover    = apportion(start_tick.turn, first_tick.turn,
                                            last_tick.turn, cur.turn, cur.stamp);
                expected_bars.push_back(bar);
            end
            if (have_last)
            begin
                start_tick  = last_tick;
                first_tick  = cur;
                run_high    = cur.price;
                run_low     = cur.price;
                minute_open = 1'b1;
            end
        end
        else if (minute_open)
        begin
            if (cur.price > run_high)
                run_high = cur.price;
            if (cur.price < run_low)
                run_low = cur.price;
        end
        last_tick = cur;
        have_last = 1'b1;
    endtask

    function automatic void check_field(input string name, input logic [63:0] want,
                                        input logic [63:0] seen);
        if (want !== seen)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, seen);
            mismatches++;
        end
    endfunction

    task automatic check_bar(input bar_t seen);
        bar_t want;
        if (expected_bars.size() == 0)
        begin
            $error("bar word with no bar pending");
            mismatches++;
            return;
        end
        want = expected_bars.pop_front();
        check_field("bar_date", 64'(want.bar_date), 64'(seen.bar_date));
        check_field("bar_time", 64'(want.bar_time), 64'(seen.bar_time));
        check_field("pre_close", 64'(want.pre_close), 64'(seen.pre_close));
        check_field("open_price", 64'(want.open_price), 64'(seen.open_price));
        check_field("close_price", 64'(want.close_price), 64'(seen.close_price));
        check_field("high_price", 64'(want.high_price), 64'(seen.high_price));
        check_field("low_price", 64'(want.low_price), 64'(seen.low_price));
        check_field("bar_volume", want.volume, seen.volume);
        check_field("bar_turnover", want.turnover, seen.turnover);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            minute_open = 1'b0;
            have_last   = 1'b0;
            start_tick  = '0;
            first_tick  = '0;
            last_tick   = '0;
            run_high    = '0;
            run_low     = '0;
            expected_bars.delete();
            mismatches  = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
                check_bar(m_tdata[M_FIELDS_W-1:0]);
            if (s_tvalid && s_tready)
                take_tick({s_tdata[S_PRICE_LSB +: PRICE_W], s_tdata[S_TIME_LSB +: TIME_W],
                           s_tdata[S_VOL_LSB +: VOL_W], s_tdata[S_TURN_LSB +: TURN_W]},
                          s_tdata[S_DATE_LSB +: DATE_W], s_tuser);
        end
        bars_pending = expected_bars.size();
    end

endmodule

// File: verif/tick_to_minute_bar_tb.sv
`timescale 1ns / 100ps

module tick_to_minute_bar_tb;
    import tmb_pkg::*;

    // chance in a hundred that a side idles in a given cycle
    localparam int IDLE_PCT     = 28;
    // cycles with no word moving on either side before the run is called dead
    localparam int STALL_LIMIT  = 20000;
    // long receiver hold-off, so the bar register fills and the input backs up
    localparam int HOLD_CYCLES  = 3000;
    // settle time after the last bar, a bit over the longest closing tick
    localparam int DRAIN_CYCLES = 500;

    localparam int RANDOM_END = 800;
    localparam int STEADY_END = 1100;
    localparam int TOTAL_END  = 1710;
    localparam int BACKLOG_MARKERS = 12;

    localparam int unsigned DAY_MS = 86400000;
    localparam int unsigned MIN_MS = 60000;

    localparam logic [PRICE_W-1:0] PRICE_TOP = '1;
    localparam logic [DATE_W-1:0]  DATE_TOP  = '1;
    localparam logic [TIME_W-1:0]  TIME_TOP  = '1;
    localparam logic [VOL_W-1:0]   VOL_TOP   = '1;
    localparam logic [TURN_W-1:0]  TURN_TOP  = '1;

    typedef enum int {PH_DIRECTED, PH_RANDOM, PH_STEADY, PH_BACKLOG, PH_TAIL} phase_t;

    logic                clk;
    logic                rst_n;
    logic                s_tvalid;
    logic                s_tready;
    // price, tick_date, tick_time, cum_volume, cum_turnover, zero fill
    logic [S_DATA_W-1:0] s_tdata;
    // new_minute
    logic                s_tuser;
    logic                m_tvalid;
    logic                m_tready;
    // bar_date, bar_time, pre_close, open_price, close_price, high_price, low_price,
    // bar_volume, bar_turnover, zero fill
    logic [M_DATA_W-1:0] m_tdata;

    int     mismatches;
    int     bars_pending;
    phase_t phase;
    bit     idle_on;
    int     ticks_sent;
    int     quiet;

    // running market, so that most ticks form believable minutes
    logic [DATE_W-1:0]  sess_date;
    int unsigned        day_ms;
    logic [VOL_W-1:0]   sess_vol;
    logic [TURN_W-1:0]  sess_turn;
    logic [PRICE_W-1:0] mkt_price;

    tick_to_minute_bar dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // watches both channels, predicts the bars and compares them
    minute_bar_checker bar_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .bars_pending (bars_pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // reset once, released away from the rising edge
    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // HHMMSSmmm from milliseconds since midnight
    function automatic logic [TIME_W-1:0] hhmmss(input int unsigned ms);
        return TIME_W'((ms / 3600000) * 10000000 + ((ms / 60000) % 60) * 100000
                       + ((ms / 1000) % 60) * 1000 + ms % 1000);
    endfunction

    // one tick word: gap first (sometimes long), then hold it until taken
    task automatic send_tick(input logic [PRICE_W-1:0] price,
                             input logic [DATE_W-1:0]  date,
                             input logic [TIME_W-1:0]  stamp,
                             input logic [VOL_W-1:0]   vol,
                             input logic [TURN_W-1:0]  turn,
                             input logic               marker);
        logic [S_DATA_W-1:0] word;
        int gap;
        word = '0;
        word[S_PRICE_LSB +: PRICE_W] = price;
        word[S_DATE_LSB +: DATE_W]   = date;
        word[S_TIME_LSB +: TIME_W]   = stamp;
        word[S_VOL_LSB +: VOL_W]     = vol;
        word[S_TURN_LSB +: TURN_W]   = turn;
        gap = 0;
        if (idle_on)
        begin
            if ($urandom_range(19) == 0)
                gap = $urandom_range(1, 400);
            else
                while ($urandom_range(99) < IDLE_PCT)
                    gap++;
        end
        @(negedge clk);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= marker;
        do
            @(posedge clk);
        while (!s_tready);
        ticks_sent++;
    endtask

    // price walk and cumulative volume and turnover for the next trade
    task automatic trade();
        int unsigned lots;
        if ($urandom_range(31) == 0)
            mkt_price = PRICE_W'($urandom);
        else
            mkt_price = PRICE_W'(mkt_price + $urandom_range(0, 200) - 100);
        lots = $urandom_range(0, 20000);
        sess_vol  = sess_vol + VOL_W'(lots);
        sess_turn = sess_turn + TURN_W'(lots) * TURN_W'($urandom_range(1, 100000));
    endtask

    // a well-formed minute: marker tick, then a few ticks later in that minute
    task automatic send_minute(input int max_ticks);
        int unsigned base;
        int unsigned at;
        int n;
        base = (day_ms / MIN_MS + 1) * MIN_MS;
        if (base + MIN_MS > DAY_MS)
        begin
            base = 9 * 3600000;
            sess_date++;
        end
        at = base + $urandom_range(0, 2000);
        // new session now and then: zero quantities just before the minute
        if ($urandom_range(39) == 0)
        begin
            sess_vol  = '0;
            sess_turn = '0;
            send_tick(mkt_price, sess_date, hhmmss(base - 1), '0, '0, 1'b0);
        end
        trade();
        send_tick(mkt_price, sess_date, hhmmss(at), sess_vol, sess_turn, 1'b1);
        n = $urandom_range(0, max_ticks);
        repeat (n)
        begin
            // same timestamp sometimes, for zero time differences
            if ($urandom_range(7) != 0)
                at = at + $urandom_range(1, 9000);
            trade();
            send_tick(mkt_price, sess_date, hhmmss(at), sess_vol, sess_turn, 1'b0);
        end
        day_ms = at;
    endtask

    // malformed word: every field random over its full width
    task automatic send_noise();
        send_tick(PRICE_W'($urandom), DATE_W'($urandom), TIME_W'($urandom),
                  VOL_W'({$urandom, $urandom}), TURN_W'({$urandom, $urandom}),
                  1'($urandom_range(1)));
    endtask

    task automatic random_until(input int last);
        while (ticks_sent < last)
        begin
            if ($urandom_range(9) == 0)
                send_noise();
            else
                send_minute(5);
        end
    endtask

    // sender side
    initial
    begin
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        idle_on    = 1'b1;
        phase      = PH_DIRECTED;
        ticks_sent = 0;
        sess_date  = DATE_W'($urandom_range(1, 99991231));
        day_ms     = 34200000;
        sess_vol   = '0;
        sess_turn  = '0;
        mkt_price  = PRICE_W'(100000);
        wait (rst_n);

        // marker with nothing before it: only remembered
        send_tick(31'd100, sess_date, 28'd93000000, 48'd0, 56'd0, 1'b1);
        send_tick(31'd101, sess_date, 28'd93000500, 48'd0, 56'd0, 1'b0);
        // first marker after traffic opens a minute with zero pre-minute quantities
        send_tick(31'd102, sess_date, 28'd93100000, 48'd10, 56'd1000, 1'b1);
        send_tick(PRICE_TOP, sess_date, 28'd93120000, 48'd20, 56'd2000, 1'b0);
        send_tick(31'd0, sess_date, 28'd93159000, 48'd30, 56'd3000, 1'b0);
        // closes with only the closing edge shared out
        send_tick(31'd500, DATE_TOP, 28'd93200000, 48'd40, 56'd4000, 1'b1);
        send_tick(31'd501, sess_date, 28'd93230000, 48'd50, 56'd5000, 1'b0);
        // marker at the same time as the last tick: zero closing edge term
        send_tick(31'd502, sess_date, 28'd93230000, 48'd60, 56'd6000, 1'b1);
        // time and quantities running backward
        send_tick(31'd503, sess_date, 28'd93220000, 48'd55, 56'd5500, 1'b0);
        send_tick(31'd504, sess_date, 28'd93210000, 48'd40, 56'd4000, 1'b1);
        send_tick(31'd7, sess_date, 28'd93300000, 48'd0, 56'd0, 1'b0);
        // full-scale jumps over one time unit: turnover quotients wrap to 64 bits
        send_tick(31'd9, sess_date, 28'd93400000, 48'd1, 56'd1, 1'b0);
        send_tick(31'd10, sess_date, 28'd93400001, VOL_TOP, TURN_TOP, 1'b1);
        // last tick past the minute mark: negative edge factor
        send_tick(31'd11, sess_date, 28'd93499999, 48'd0, 56'd0, 1'b0);
        send_tick(31'd12, sess_date, 28'd93500000, VOL_TOP, TURN_TOP, 1'b1);
        send_tick(PRICE_TOP, DATE_TOP, TIME_TOP, VOL_TOP, TURN_TOP, 1'b0);
        send_tick(31'd0, 27'd0, 28'd0, 48'd0, 56'd0, 1'b1);
        // minute of a single tick
        send_tick(31'd0, 27'd0, 28'd0, 48'd0, 56'd0, 1'b1);

        phase = PH_RANDOM;
        random_until(RANDOM_END);

        // a long stretch with neither side idling
        phase   = PH_STEADY;
        idle_on = 1'b0;
        random_until(STEADY_END);

        // receiver holds off while markers keep coming
        phase = PH_BACKLOG;
        repeat (BACKLOG_MARKERS) send_minute(0);

        phase   = PH_TAIL;
        idle_on = 1'b1;
        random_until(TOTAL_END);

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (bars_pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatches == 0 && bars_pending == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // receiver side: random stalls, one long hold-off during the backlog phase
    initial
    begin : receiver
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (phase == PH_BACKLOG && !held)
            begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else
            begin
                m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    // watchdog on cycles where no word moves on either side
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

endmodule

// File: sim.f
rtl/core/tmb_pkg.sv
rtl/core/tick_to_minute_bar.sv
rtl/core/tmb_checker.sv
verif/minute_bar_checker.sv
verif/tick_to_minute_bar_tb.sv
